// File: hdl/pcc_pkg.sv
// Package for the packet CRC-8 and channel checker.
// Holds codes, widths, the controller/datapath bundles and the CRC-8 byte update.
// Used by every other file of the block; depends on nothing.
package pcc_pkg;

  localparam int FIXUP_LIMIT = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [7:0] CRC_POLY = 8'h8c;

  localparam logic [7:0] START_DELIM_RST  = 8'd60;
  localparam logic [7:0] COLUMN_DELIM_RST = 8'd59;
  localparam logic [7:0] END_DELIM_RST    = 8'd62;
  localparam logic [7:0] CRC_INIT_RST     = 8'd0;
  localparam logic [7:0] CRC_EXTRA_RST    = 8'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_DELIM      = 3'd0,
    CFG_COLUMN_DELIM     = 3'd1,
    CFG_END_DELIM        = 3'd2,
    CFG_CRC_INIT         = 3'd3,
    CFG_CRC_EXTRA        = 3'd4,
    CFG_EXPECTED_CHANNEL = 3'd5,
    CFG_CRC_CHECK_ENABLE = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_CRC_ERR       = 2'd1,
    ST_FORMAT_ERR    = 2'd2,
    ST_WRONG_CHANNEL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_PRE    = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic accept;
    logic fixup_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fixup_done;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data_in;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'd48) && (b <= 8'd57);
  endfunction

endpackage

// File: hdl/pcc_if.sv
// Handshake channels of the packet CRC-8 and channel checker.
// Byte input, status result and register write channels; depends on pcc_pkg.
interface pcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  modport source (output valid, data_byte, is_last, input ready);
  modport sink (input valid, data_byte, is_last, output ready);
  modport monitor (input valid, ready, data_byte, is_last);
endinterface

interface pcc_status_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] channel_seen;
  logic [7:0]  crc_received;
  logic [7:0]  crc_computed;
  modport source (output valid, status, channel_seen, crc_received, crc_computed,
                  input ready);
  modport sink (input valid, status, channel_seen, crc_received, crc_computed,
                output ready);
  modport monitor (input valid, ready, status, channel_seen, crc_received, crc_computed);
endinterface

interface pcc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pcc_pkg::CFG_INDEX_W-1:0]    index;
  logic [pcc_pkg::CFG_DATA_W-1:0]     value;
  modport source (output valid, index, value, input ready);
  modport sink (input valid, index, value, output ready);
endinterface

// File: hdl/pcc_ctrl.sv
// Controller of the packet CRC-8 and channel checker.
// Sequences byte intake, the end-of-packet CRC remap and the result load; uses pcc_pkg.
module pcc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  pcc_pkg::sts_t   sts,
  output pcc_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_RUN   = 3'b001,
    S_FIXUP = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_RUN);
    case (state)
      S_RUN: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_last) begin
            state_next = S_FIXUP;
          end
        end
      end
      S_FIXUP: begin
        if (sts.fixup_done) begin
          state_next = S_EMIT;
        end else begin
          cmd.fixup_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

endmodule

// File: hdl/pcc_datapath.sv
// Datapath of the packet CRC-8 and channel checker.
// Register file, CRC register and byte delay line, channel parser and result register.
// Driven by pcc_ctrl commands; uses pcc_pkg.
module pcc_datapath #(
  parameter int FIXUP_LIMIT = pcc_pkg::FIXUP_LIMIT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pcc_pkg::cmd_t                   cmd,
  output pcc_pkg::sts_t                   sts,
  input  logic [7:0]                      data_byte,
  input  logic                            cfg_valid,
  input  logic [pcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]  cfg_value,
  output logic                            cfg_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic signed [15:0]              channel_seen,
  output logic [7:0]                      crc_received,
  output logic [7:0]                      crc_computed
);

  localparam int RW = $clog2(FIXUP_LIMIT + 1);

  logic [7:0]        start_delim;
  logic [7:0]        column_delim;
  logic [7:0]        end_delim;
  logic [7:0]        crc_init;
  logic [7:0]        crc_extra;
  logic signed [15:0] expected_channel;
  logic              crc_check_enable;

  logic [7:0]        crc_value;
  logic [7:0]        held0;
  logic [7:0]        held1;
  logic [1:0]        bytes_seen;
  pcc_pkg::phase_t   phase;
  pcc_pkg::phase_t   phase_next;
  logic              is_negative;
  logic              is_negative_next;
  logic [15:0]       magnitude;
  logic [15:0]       magnitude_next;
  logic              digit_found;
  logic              digit_found_next;
  logic [RW-1:0]     rounds;

  logic [19:0]       mag_sum;
  logic [15:0]       mag_digit;
  logic              short_packet;
  logic              forbidden;
  logic signed [15:0] ch_value;
  logic [7:0]        rx_value;
  logic [7:0]        calc_value;
  pcc_pkg::status_t  status_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delim      <= pcc_pkg::START_DELIM_RST;
      column_delim     <= pcc_pkg::COLUMN_DELIM_RST;
      end_delim        <= pcc_pkg::END_DELIM_RST;
      crc_init         <= pcc_pkg::CRC_INIT_RST;
      crc_extra        <= pcc_pkg::CRC_EXTRA_RST;
      expected_channel <= '0;
      crc_check_enable <= 1'b1;
    end else if (cfg_valid) begin
      case (pcc_pkg::cfg_reg_t'(cfg_index))
        pcc_pkg::CFG_START_DELIM:      start_delim      <= cfg_value[7:0];
        pcc_pkg::CFG_COLUMN_DELIM:     column_delim     <= cfg_value[7:0];
        pcc_pkg::CFG_END_DELIM:        end_delim        <= cfg_value[7:0];
        pcc_pkg::CFG_CRC_INIT:         crc_init         <= cfg_value[7:0];
        pcc_pkg::CFG_CRC_EXTRA:        crc_extra        <= cfg_value[7:0];
        pcc_pkg::CFG_EXPECTED_CHANNEL: expected_channel <= cfg_value[15:0];
        pcc_pkg::CFG_CRC_CHECK_ENABLE: crc_check_enable <= cfg_value[0];
        default: begin
        end
      endcase
    end
  end

  // A digit's value is its low nibble; magnitude times ten is two shifts.
  assign mag_sum = ({4'd0, magnitude} << 3) + ({4'd0, magnitude} << 1)
                   + {16'd0, data_byte[3:0]};
  assign mag_digit = (|mag_sum[19:16]) ? 16'hffff : mag_sum[15:0];

  always_comb begin
    phase_next       = phase;
    is_negative_next = is_negative;
    magnitude_next   = magnitude;
    digit_found_next = digit_found;
    case (phase)
      pcc_pkg::PH_START: begin
        phase_next = (data_byte == start_delim) ? pcc_pkg::PH_PRE : pcc_pkg::PH_DONE;
      end
      pcc_pkg::PH_PRE: begin
        if (pcc_pkg::is_space(data_byte)) begin
          phase_next = pcc_pkg::PH_PRE;
        end else if (data_byte == 8'd43 || data_byte == 8'd45) begin
          is_negative_next = (data_byte == 8'd45);
          phase_next       = pcc_pkg::PH_DIGITS;
        end else if (pcc_pkg::is_digit(data_byte)) begin
          magnitude_next   = mag_digit;
          digit_found_next = 1'b1;
          phase_next       = pcc_pkg::PH_DIGITS;
        end else begin
          phase_next = pcc_pkg::PH_DONE;
        end
      end
      pcc_pkg::PH_DIGITS: begin
        if (pcc_pkg::is_digit(data_byte)) begin
          magnitude_next   = mag_digit;
          digit_found_next = 1'b1;
        end else begin
          phase_next = pcc_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen  <= '0;
      phase       <= pcc_pkg::PH_START;
      is_negative <= 1'b0;
      magnitude   <= '0;
      digit_found <= 1'b0;
      rounds      <= '0;
    end else if (cmd.emit) begin
      bytes_seen  <= '0;
      phase       <= pcc_pkg::PH_START;
      is_negative <= 1'b0;
      magnitude   <= '0;
      digit_found <= 1'b0;
    end else if (cmd.accept) begin
      if (bytes_seen != 2'd2) begin
        bytes_seen <= bytes_seen + 2'd1;
      end
      phase       <= phase_next;
      is_negative <= is_negative_next;
      magnitude   <= magnitude_next;
      digit_found <= digit_found_next;
      rounds      <= '0;
    end else if (cmd.fixup_step) begin
      rounds <= rounds + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      crc_value <= (bytes_seen != 2'd2) ? crc_init : pcc_pkg::crc8_step(crc_value, held0);
      held0     <= held1;
      held1     <= data_byte;
    end else if (cmd.fixup_step) begin
      crc_value <= pcc_pkg::crc8_step(crc_value, crc_extra);
    end
  end

  assign short_packet = (bytes_seen != 2'd2);
  assign forbidden = (crc_value == start_delim) || (crc_value == column_delim)
                     || (crc_value == end_delim) || (crc_value == 8'd0);

  assign sts.fixup_done = short_packet || !forbidden || (rounds == RW'(FIXUP_LIMIT));
  assign sts.out_free   = !out_valid || out_ready;

  always_comb begin
    if (!digit_found) begin
      ch_value = '0;
    end else if (is_negative) begin
      ch_value = magnitude[15] ? 16'sh8000 : -$signed(magnitude);
    end else begin
      ch_value = (magnitude >= 16'd32767) ? 16'sh7fff : $signed(magnitude);
    end
    rx_value   = short_packet ? 8'd0 : held0;
    calc_value = short_packet ? 8'd0 : crc_value;
    if (short_packet) begin
      status_value = pcc_pkg::ST_FORMAT_ERR;
    end else if (crc_check_enable && (rx_value != calc_value)) begin
      status_value = pcc_pkg::ST_CRC_ERR;
    end else if (!digit_found) begin
      status_value = pcc_pkg::ST_FORMAT_ERR;
    end else if (ch_value != expected_channel) begin
      status_value = pcc_pkg::ST_WRONG_CHANNEL;
    end else begin
      status_value = pcc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status       <= status_value;
      channel_seen <= ch_value;
      crc_received <= rx_value;
      crc_computed <= calc_value;
    end
  end

endmodule

// File: hdl/packet_crc8_channel_checker.sv
// Top level of the packet CRC-8 and channel checker.
// Joins pcc_ctrl and pcc_datapath to the byte, result and register channels.
// Depends on pcc_pkg and the channel interfaces in pcc_if.sv.

// Bytes of a packet are taken one per cycle. After the byte marked last, the
// input is held off while the CRC is remapped, one CRC-8 byte update of the
// extra byte per cycle, for R rounds (0 to FIXUP_LIMIT), until the remap is
// seen to be done; the result is then loaded into the output register once
// the previous result has been taken.
// Register writes are accepted in every cycle and should be made between packets.
module packet_crc8_channel_checker #(
  parameter int FIXUP_LIMIT = pcc_pkg::FIXUP_LIMIT
) (
  input  logic         clk,
  input  logic         rst,
  pcc_byte_if.sink     data,
  pcc_status_if.source result,
  pcc_cfg_if.sink      cfg
);

  pcc_pkg::cmd_t cmd;
  pcc_pkg::sts_t sts;

  pcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (data.valid),
    .in_last  (data.is_last),
    .in_ready (data.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcc_datapath #(
    .FIXUP_LIMIT (FIXUP_LIMIT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .data_byte    (data.data_byte),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_value    (cfg.value),
    .cfg_ready    (cfg.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .status       (result.status),
    .channel_seen (result.channel_seen),
    .crc_received (result.crc_received),
    .crc_computed (result.crc_computed)
  );

endmodule

// File: hdl/pcc_checker.sv
// Port-level checks for packet_crc8_channel_checker, attached by bind.
// Depends on pcc_pkg.
module pcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [7:0] crc_received,
  input logic [7:0] crc_computed
);

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("Input ready right after a packet end.");

  a_crc_err_differs: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == pcc_pkg::ST_CRC_ERR)
    |-> (crc_received != crc_computed))
    else $error("CRC error reported on matching CRC bytes.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready
    |=> out_valid && $stable(status) && $stable(crc_computed))
    else $error("Stalled result changed.");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid after reset.");

endmodule

bind packet_crc8_channel_checker pcc_checker u_pcc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (data.valid),
  .in_ready     (data.ready),
  .in_last      (data.is_last),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .status       (result.status),
  .crc_received (result.crc_received),
  .crc_computed (result.crc_computed)
);
